@@ design/pgp_pkg.sv @@
// Shared types and constants of the pixel to ground-plane point block.
package pgp_pkg;

  // Configuration port widths.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IW-1:0] {
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_TRANS,
    REG_FOCAL,
    REG_PP
  } pgp_reg_t;

  // Magnitude limit of depth and camera values (2^40).
  localparam logic [41:0] PGP_LIM = 42'd1 << 40;

  // Input word: one pixel coordinate.
  typedef struct packed {
    logic [15:0] pixel_u;
    logic [15:0] pixel_v;
  } pgp_in_t;

  // Output word: camera point, world point and status.
  typedef struct packed {
    logic signed [23:0] cam_x;
    logic signed [23:0] cam_y;
    logic signed [23:0] cam_z;
    logic signed [23:0] world_x;
    logic signed [23:0] world_y;
    logic signed [23:0] world_z;
    logic               degenerate;
  } pgp_out_t;

endpackage

@@ design/pgp_div.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
module pgp_div
  import pgp_pkg::*;
#(
  parameter int QW = 44,
  parameter int DW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_bits,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [DW-1:0] out_rem,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic          vld_r  [QW];
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] bits_r [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_i;
    logic [DW-1:0] rem_i;
    logic [QW-1:0] bits_i;
    logic [QW-1:0] quo_i;
    logic [DW-1:0] den_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic          take;

    // Stage inputs come from the ports or from the stage before.
    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rem_i  = in_rem;
      assign bits_i = in_bits;
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign bits_i = bits_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign den_i  = den_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Shift in the next numerator bit and subtract the divisor where it fits.
    assign trial = {rem_i, bits_i[QW-1]};
    assign take  = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (take) begin
        rem_r[k] <= DW'(trial - {1'b0, den_i});
      end else begin
        rem_r[k] <= trial[DW-1:0];
      end
      bits_r[k] <= {bits_i[QW-2:0], 1'b0};
      quo_r[k]  <= {quo_i[QW-2:0], take};
      den_r[k]  <= den_i;
      side_r[k] <= side_i;
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_rem   = rem_r[QW-1];
  assign out_den   = den_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ design/pixel_to_ground_plane_point_top.sv @@
// Top level of the pixel to ground-plane point back-projection pipeline.
//
// A pixel word is taken on in_word at every rising edge where start is high
// and busy is low. busy is always low, so a new pixel may enter every cycle.
// Each pixel gives one output word on out_word, marked by a one-cycle
// out_valid strobe. The pipeline is built from three pipelined long divide
// steps (normalized coordinates, 44 stages; depth, 41 stages; camera x/y,
// 41 stages) plus the multiply, rounding and clamping stages around them.
// Throughput is one word a cycle.
// The receiver cannot stall, so nothing in the pipe ever holds.
// Calibration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high. Write them only while no pixel is in flight.
// Synchronous reset clears the registers to zero and empties the pipeline.
// A zero focal length or a ray parallel to the ground plane gives an all-zero
// word with degenerate set; saturation also sets degenerate.
module pixel_to_ground_plane_point_top
  import pgp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pgp_in_t           in_word,
  output logic              out_valid,
  output pgp_out_t          out_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int NQ_QW  = 44;
  localparam int DEP_QW = 41;
  localparam int CAM_QW = 41;
  localparam int LAT    = 1 + NQ_QW + 4 + DEP_QW + 3 + CAM_QW + 5;

  // Configuration registers.
  logic [47:0] rot_r [3];
  logic [59:0] trans_r;
  logic [47:0] focal_r;
  logic [31:0] pp_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= '0;
      rot_r[1] <= '0;
      rot_r[2] <= '0;
      trans_r  <= '0;
      focal_r  <= '0;
      pp_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROT0:  rot_r[0] <= cfg_data[47:0];
        REG_ROT1:  rot_r[1] <= cfg_data[47:0];
        REG_ROT2:  rot_r[2] <= cfg_data[47:0];
        REG_TRANS: trans_r  <= cfg_data[59:0];
        REG_FOCAL: focal_r  <= cfg_data[47:0];
        REG_PP:    pp_r     <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  // Field views of the registers.
  logic signed [15:0] rm [3][3];
  logic signed [19:0] tv [3];
  logic [23:0] fx;
  logic [23:0] fy;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rm[r][c] = rot_r[r][16*c +: 16];
      end
      tv[r] = trans_r[20*r +: 20];
    end
  end

  assign fx = focal_r[23:0];
  assign fy = focal_r[47:24];

  // Numerator of the depth: the z row of R^T times t, from the registers only.
  logic signed [35:0] lzp_r [3];
  logic signed [37:0] lz_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      lzp_r[k] <= rm[k][2] * tv[k];
    end
    lz_r <= 38'(lzp_r[0]) + 38'(lzp_r[1]) + 38'(lzp_r[2]);
  end

  // Stage 0: pixel offsets from the principal point.
  logic               v0_r;
  logic signed [16:0] du0_r;
  logic signed [16:0] dv0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    du0_r <= signed'({1'b0, in_word.pixel_u}) - signed'({1'b0, pp_r[15:0]});
    dv0_r <= signed'({1'b0, in_word.pixel_v}) - signed'({1'b0, pp_r[31:16]});
  end

  // Normalized coordinates a = du/fx and b = dv/fy in Q24.
  logic [15:0] dum0;
  logic [15:0] dvm0;
  logic              va;
  logic              vb;
  logic [NQ_QW-1:0]  qa;
  logic [NQ_QW-1:0]  qb;
  logic [23:0]       ra;
  logic [23:0]       rb;
  logic [23:0]       dena;
  logic [23:0]       denb;
  logic [34:0]       sidea;
  logic              sideb;

  assign dum0 = du0_r[16] ? 16'(-du0_r) : du0_r[15:0];
  assign dvm0 = dv0_r[16] ? 16'(-dv0_r) : dv0_r[15:0];

  pgp_div #(.QW(NQ_QW), .DW(24), .SW(35)) u_div_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_rem   ('0),
    .in_bits  ({dum0, 28'b0}),
    .in_den   (fx),
    .in_side  ({du0_r, dv0_r, du0_r[16]}),
    .out_valid(va),
    .out_quo  (qa),
    .out_rem  (ra),
    .out_den  (dena),
    .out_side (sidea)
  );

  pgp_div #(.QW(NQ_QW), .DW(24), .SW(1)) u_div_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v0_r),
    .in_rem   ('0),
    .in_bits  ({dvm0, 28'b0}),
    .in_den   (fy),
    .in_side  (dv0_r[16]),
    .out_valid(vb),
    .out_quo  (qb),
    .out_rem  (rb),
    .out_den  (denb),
    .out_side (sideb)
  );

  // Stage 1: round the normalized coordinates.
  logic [44:0]        amag;
  logic [44:0]        bmag;
  logic               v1_r;
  logic signed [44:0] a1_r;
  logic signed [44:0] b1_r;
  logic signed [16:0] du1_r;
  logic signed [16:0] dv1_r;

  assign amag = {1'b0, qa} + 45'({ra, 1'b0} >= {1'b0, dena});
  assign bmag = {1'b0, qb} + 45'({rb, 1'b0} >= {1'b0, denb});

  // Stages 1 to 4: denominator of the depth and its magnitude.
  logic               v2_r;
  logic               v3_r;
  logic               v4_r;
  logic signed [60:0] pa2_r;
  logic signed [60:0] pb2_r;
  logic signed [16:0] du2_r;
  logic signed [16:0] dv2_r;
  logic signed [62:0] rz3_r;
  logic signed [16:0] du3_r;
  logic signed [16:0] dv3_r;
  logic [61:0]        den4_r;
  logic [37:0]        num4_r;
  logic               neg4_r;
  logic               zero4_r;
  logic signed [16:0] du4_r;
  logic signed [16:0] dv4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= va && vb;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    a1_r    <= sidea[0] ? signed'(-amag) : signed'(amag);
    b1_r    <= sideb ? signed'(-bmag) : signed'(bmag);
    du1_r   <= sidea[34:18];
    dv1_r   <= sidea[17:1];
    pa2_r   <= rm[0][2] * a1_r;
    pb2_r   <= rm[1][2] * b1_r;
    du2_r   <= du1_r;
    dv2_r   <= dv1_r;
    rz3_r   <= 63'(pa2_r) + 63'(pb2_r) + (63'(rm[2][2]) <<< 24);
    du3_r   <= du2_r;
    dv3_r   <= dv2_r;
    den4_r  <= rz3_r[62] ? 62'(-rz3_r) : rz3_r[61:0];
    num4_r  <= lz_r[37] ? 38'(-lz_r) : lz_r;
    neg4_r  <= rz3_r[62] ^ lz_r[37];
    zero4_r <= (rz3_r == '0);
    du4_r   <= du3_r;
    dv4_r   <= dv3_r;
  end

  // Depth = lz * 2^32 / rz; a quotient of 2^41 or more saturates up front.
  logic              dep_pre;
  logic              vd;
  logic [DEP_QW-1:0] qd;
  logic [61:0]       rd;
  logic [61:0]       dend;
  logic [36:0]       sided;

  assign dep_pre = ({33'b0, num4_r} >= {den4_r, 9'b0});

  pgp_div #(.QW(DEP_QW), .DW(62), .SW(37)) u_div_depth (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v4_r),
    .in_rem   (62'(num4_r[37:9])),
    .in_bits  ({num4_r[8:0], 32'b0}),
    .in_den   (den4_r),
    .in_side  ({du4_r, dv4_r, neg4_r, zero4_r, dep_pre}),
    .out_valid(vd),
    .out_quo  (qd),
    .out_rem  (rd),
    .out_den  (dend),
    .out_side (sided)
  );

  // Stage 5: round and limit the depth.
  logic [41:0] dmag;
  logic        dsat;
  logic [41:0] dlim;

  assign dmag = {1'b0, qd} + 42'({rd, 1'b0} >= {1'b0, dend});
  assign dsat = sided[0] || (dmag > PGP_LIM);
  assign dlim = dsat ? PGP_LIM : dmag;

  logic               v5_r;
  logic signed [41:0] dep5_r;
  logic               sat5_r;
  logic               zero5_r;
  logic signed [16:0] du5_r;
  logic signed [16:0] dv5_r;

  // Stages 6 and 7: ray scaling by depth, then magnitudes for the divide.
  logic [40:0]        zmag;
  logic [40:0]        zrnd;
  logic               v6_r;
  logic               v7_r;
  logic signed [58:0] px6_r;
  logic signed [58:0] py6_r;
  logic signed [41:0] cz6_r;
  logic               sat6_r;
  logic               zero6_r;
  logic [57:0]        mx7_r;
  logic [57:0]        my7_r;
  logic               nx7_r;
  logic               ny7_r;
  logic signed [41:0] cz7_r;
  logic               sat7_r;
  logic               zero7_r;

  assign zmag = dep5_r[41] ? 41'(-dep5_r) : dep5_r[40:0];
  assign zrnd = (zmag + 41'd128) >> 8;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v5_r <= vd;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    dep5_r  <= sided[2] ? signed'(-dlim) : signed'(dlim);
    sat5_r  <= dsat;
    zero5_r <= sided[1];
    du5_r   <= sided[36:20];
    dv5_r   <= sided[19:3];
    px6_r   <= du5_r * dep5_r;
    py6_r   <= dv5_r * dep5_r;
    cz6_r   <= dep5_r[41] ? signed'(-42'(zrnd)) : signed'(42'(zrnd));
    sat6_r  <= sat5_r;
    zero6_r <= zero5_r;
    mx7_r   <= px6_r[58] ? 58'(-px6_r) : px6_r[57:0];
    my7_r   <= py6_r[58] ? 58'(-py6_r) : py6_r[57:0];
    nx7_r   <= px6_r[58];
    ny7_r   <= py6_r[58];
    cz7_r   <= cz6_r;
    sat7_r  <= sat6_r;
    zero7_r <= zero6_r;
  end

  // Camera x and y: du*depth / (16*fx); a quotient of 2^41 or more saturates.
  logic [27:0]       denx0;
  logic [27:0]       deny0;
  logic              prex;
  logic              prey;
  logic              vcx;
  logic              vcy;
  logic [CAM_QW-1:0] qcx;
  logic [CAM_QW-1:0] qcy;
  logic [27:0]       rcx;
  logic [27:0]       rcy;
  logic [27:0]       dencx;
  logic [27:0]       dency;
  logic [45:0]       sidecx;
  logic [1:0]        sidecy;

  assign denx0 = {fx, 4'b0};
  assign deny0 = {fy, 4'b0};
  assign prex  = ({11'b0, mx7_r} >= {denx0, 41'b0});
  assign prey  = ({11'b0, my7_r} >= {deny0, 41'b0});

  pgp_div #(.QW(CAM_QW), .DW(28), .SW(46)) u_div_cx (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v7_r),
    .in_rem   (28'(mx7_r[57:41])),
    .in_bits  (mx7_r[40:0]),
    .in_den   (denx0),
    .in_side  ({nx7_r, prex, cz7_r, sat7_r, zero7_r}),
    .out_valid(vcx),
    .out_quo  (qcx),
    .out_rem  (rcx),
    .out_den  (dencx),
    .out_side (sidecx)
  );

  pgp_div #(.QW(CAM_QW), .DW(28), .SW(2)) u_div_cy (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v7_r),
    .in_rem   (28'(my7_r[57:41])),
    .in_bits  (my7_r[40:0]),
    .in_den   (deny0),
    .in_side  ({ny7_r, prey}),
    .out_valid(vcy),
    .out_quo  (qcy),
    .out_rem  (rcy),
    .out_den  (dency),
    .out_side (sidecy)
  );

  // Stage 8: round and limit the camera point.
  logic [41:0] cxmag;
  logic [41:0] cymag;
  logic        cxsat;
  logic        cysat;
  logic [41:0] cxlim;
  logic [41:0] cylim;

  assign cxmag = {1'b0, qcx} + 42'({rcx, 1'b0} >= {1'b0, dencx});
  assign cymag = {1'b0, qcy} + 42'({rcy, 1'b0} >= {1'b0, dency});
  assign cxsat = sidecx[44] || (cxmag > PGP_LIM);
  assign cysat = sidecy[0] || (cymag > PGP_LIM);
  assign cxlim = cxsat ? PGP_LIM : cxmag;
  assign cylim = cysat ? PGP_LIM : cymag;

  // Stages 8 to 11: world point R^T (cam - t) in Q18.
  logic               v8_r;
  logic               v9_r;
  logic               v10_r;
  logic               v11_r;
  logic signed [41:0] cam8_r  [3];
  logic signed [41:0] cam9_r  [3];
  logic signed [41:0] cam10_r [3];
  logic signed [41:0] cam11_r [3];
  logic signed [42:0] diff9_r [3];
  logic signed [58:0] prod10_r [3][3];
  logic signed [60:0] acc11_r [3];
  logic               sat8_r;
  logic               sat9_r;
  logic               sat10_r;
  logic               sat11_r;
  logic               zero8_r;
  logic               zero9_r;
  logic               zero10_r;
  logic               zero11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
      v11_r <= 1'b0;
    end else begin
      v8_r  <= vcx && vcy;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
    end
  end

  always_ff @(posedge clk) begin
    cam8_r[0] <= sidecx[45] ? signed'(-cxlim) : signed'(cxlim);
    cam8_r[1] <= sidecy[1] ? signed'(-cylim) : signed'(cylim);
    cam8_r[2] <= sidecx[43:2];
    sat8_r    <= sidecx[1] || cxsat || cysat;
    zero8_r   <= sidecx[0];
    for (int k = 0; k < 3; k++) begin
      diff9_r[k] <= 43'(cam8_r[k]) - 43'(tv[k]);
      cam9_r[k]  <= cam8_r[k];
      cam10_r[k] <= cam9_r[k];
      cam11_r[k] <= cam10_r[k];
      for (int c = 0; c < 3; c++) begin
        prod10_r[k][c] <= rm[k][c] * diff9_r[k];
      end
      acc11_r[k] <= 61'(prod10_r[0][k]) + 61'(prod10_r[1][k]) + 61'(prod10_r[2][k]);
    end
    sat9_r   <= sat8_r;
    sat10_r  <= sat9_r;
    sat11_r  <= sat10_r;
    zero9_r  <= zero8_r;
    zero10_r <= zero9_r;
    zero11_r <= zero10_r;
  end

  // Clamp to the 24-bit output range; the top bit flags a clamp.
  function automatic logic [24:0] clamp24(input logic signed [47:0] x);
    logic [24:0] res;
    if (x > 48'sd8388607) begin
      res = {1'b1, 24'h7FFFFF};
    end else if (x < -48'sd8388608) begin
      res = {1'b1, 24'h800000};
    end else begin
      res = {1'b0, x[23:0]};
    end
    return res;
  endfunction

  // Output stage: round the world point from Q18 to Q4, clamp everything.
  logic [59:0]        wmag [3];
  logic [46:0]        wrnd [3];
  logic signed [47:0] wval [3];
  logic [24:0]        cclp [3];
  logic [24:0]        wclp [3];
  pgp_out_t           out_nxt;
  logic               out_valid_r;
  pgp_out_t           out_word_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wmag[k] = acc11_r[k][60] ? 60'(-acc11_r[k]) : acc11_r[k][59:0];
      wrnd[k] = 47'((61'(wmag[k]) + 61'd8192) >> 14);
      wval[k] = acc11_r[k][60] ? signed'(-48'(wrnd[k])) : signed'(48'(wrnd[k]));
      cclp[k] = clamp24(48'(cam11_r[k]));
      wclp[k] = clamp24(wval[k]);
    end
  end

  always_comb begin
    out_nxt = '0;
    if (fx == '0 || fy == '0 || zero11_r) begin
      out_nxt.degenerate = 1'b1;
    end else begin
      out_nxt.cam_x      = cclp[0][23:0];
      out_nxt.cam_y      = cclp[1][23:0];
      out_nxt.cam_z      = cclp[2][23:0];
      out_nxt.world_x    = wclp[0][23:0];
      out_nxt.world_y    = wclp[1][23:0];
      out_nxt.world_z    = wclp[2][23:0];
      out_nxt.degenerate = sat11_r || cclp[0][24] || cclp[1][24] || cclp[2][24] ||
                           wclp[0][24] || wclp[1][24] || wclp[2][24];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v11_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  // Every result word traces back to a pixel taken a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a matching pixel");

  // A focal length write lands in its register on the next edge.
  a_cfg_focal: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_FOCAL) |=>
      (focal_r == $past(cfg_data[47:0])))
    else $error("focal length write lost");

  // A zero fx focal length yields a flagged word with zero cam_z and world_x.
  a_zero_focal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && fx == '0) |->
      (out_word.degenerate && out_word.cam_z == '0 && out_word.world_x == '0))
    else $error("zero focal length not flagged");
`endif

endmodule
